### design/wsk_pkg.sv
// shared types, constants and scale tables for the key-to-note unit
package wsk_pkg;

  localparam int MAX_KEYS       = 8;
  localparam int OFF_W          = 8;   // signed scale offset in semitones
  localparam int PROD_W         = 17;  // unsigned 8 bit weight times signed offset
  localparam int NUM_W          = 21;  // signed weighted sum
  localparam int DEN_W          = 12;  // sum of weights, at most 9 * 255
  localparam int MAG_W          = 28;  // magnitude of weighted sum times 256
  localparam int QUO_W          = 15;  // magnitude of mean in Q7.8
  localparam int BITS_PER_STAGE = 3;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  localparam logic [1:0] CFG_TONIC  = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_OCTAVE = 2'd2;

  localparam int MODE_NONE = 0;
  localparam int MODE_HIGH = 1;
  localparam int MODE_LOW  = 2;
  localparam int MODES     = 3;

  localparam int SCALE_IV [8][7] = '{
    '{2, 2, 1, 2, 2, 2, 1},
    '{2, 1, 2, 2, 1, 2, 2},
    '{2, 2, 3, 2, 3, 0, 0},
    '{3, 2, 1, 1, 3, 2, 0},
    '{2, 0, 0, 0, 0, 0, 0},
    '{2, 1, 0, 0, 0, 0, 0},
    '{1, 2, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0}
  };
  localparam int SCALE_REP [8] = '{7, 7, 5, 6, 1, 2, 2, 1};
  localparam int SCALE_OCT [8] = '{7, 7, 5, 6, 6, 8, 8, 12};
  // 12 / (octave / repeat) for the short-repeat scales
  localparam int MAG_UNIT  [8] = '{0, 0, 0, 0, 2, 3, 3, 1};

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  // scale offset of one slot (0 = open key), evaluated at elaboration only
  function automatic int calc_off(int scale, int mode, int slot, int keys);
    int rep;
    int oct;
    int bk;
    int boff;
    int k;
    int off;
    rep  = SCALE_REP[scale];
    oct  = SCALE_OCT[scale];
    bk   = 0;
    boff = 0;
    if (mode != MODE_NONE) begin
      boff = (rep <= 2) ? (keys + 1) * MAG_UNIT[scale] : 12;
      if (mode == MODE_HIGH) begin
        bk = keys + 1;
      end else begin
        bk   = -(keys + 1);
        boff = -boff;
      end
      for (int n = 0; n < 16; n++) begin
        if (bk < 0) bk = bk + oct;
      end
    end
    k = bk;
    for (int n = 0; n < 64; n++) begin
      if (k >= rep) k = k - rep;
    end
    off = boff;
    for (int i = 0; i < MAX_KEYS + 1; i++) begin
      if (i < slot) begin
        off = off + SCALE_IV[scale][k];
        k   = k + 1;
        if (k == rep) k = 0;
      end
    end
    return off;
  endfunction

endpackage

### design/wsk_front.sv
// offset lookup, open-key weight, products and sums (four register stages)
module wsk_front #(
  parameter int KEYS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [63:0]                       key_depths,
  input  logic                              high_register,
  input  logic                              low_register,
  input  logic [2:0]                        scale_type,
  output logic                              valid_o,
  output logic signed [wsk_pkg::NUM_W-1:0]  num_o,
  output logic [wsk_pkg::DEN_W-1:0]         den_o
);

  localparam int OW = wsk_pkg::OFF_W;

  logic signed [OW-1:0] tab [8][wsk_pkg::MODES][KEYS+1];

  for (genvar s = 0; s < 8; s++) begin : g_s
    for (genvar m = 0; m < wsk_pkg::MODES; m++) begin : g_m
      for (genvar j = 0; j <= KEYS; j++) begin : g_j
        localparam int OFF = wsk_pkg::calc_off(s, m, j, KEYS);
        assign tab[s][m][j] = OW'(OFF);
      end
    end
  end

  logic [1:0] mode;
  always_comb begin
    if (high_register && !low_register) begin
      mode = 2'(wsk_pkg::MODE_HIGH);
    end else if (low_register && !high_register) begin
      mode = 2'(wsk_pkg::MODE_LOW);
    end else begin
      mode = 2'(wsk_pkg::MODE_NONE);
    end
  end

  // stage 1
  logic                 v1_r;
  logic [7:0]           dep1_r [KEYS];
  logic signed [OW-1:0] off1_r [KEYS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < KEYS; i++) dep1_r[i] <= key_depths[8*i +: 8];
      for (int j = 0; j <= KEYS; j++) off1_r[j] <= tab[scale_type][mode][j];
    end
  end

  // open key weight
  logic [7:0] maxd;
  logic [3:0] down;
  logic [7:0] w0;
  always_comb begin
    maxd = 8'd0;
    down = 4'd0;
    for (int i = 0; i < KEYS; i++) begin
      if (dep1_r[i] > maxd) maxd = dep1_r[i];
      down = down + {3'b0, (dep1_r[i] != 8'd0)};
    end
    w0 = (down <= 4'd1) ? (8'd255 - maxd) : 8'd0;
  end

  // stage 2
  logic                 v2_r;
  logic [7:0]           w2_r   [KEYS+1];
  logic signed [OW-1:0] off2_r [KEYS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2_r[0] <= w0;
      for (int i = 0; i < KEYS; i++) w2_r[i+1] <= dep1_r[i];
      for (int j = 0; j <= KEYS; j++) off2_r[j] <= off1_r[j];
    end
  end

  logic [wsk_pkg::DEN_W-1:0] den_sum;
  always_comb begin
    den_sum = '0;
    for (int j = 0; j <= KEYS; j++) den_sum = den_sum + {4'b0, w2_r[j]};
  end

  // stage 3
  logic                                  v3_r;
  logic signed [wsk_pkg::PROD_W-1:0]     prod3_r [KEYS+1];
  logic [wsk_pkg::DEN_W-1:0]             den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= KEYS; j++) begin
        prod3_r[j] <= $signed({1'b0, w2_r[j]}) * off2_r[j];
      end
      den3_r <= den_sum;
    end
  end

  logic signed [wsk_pkg::NUM_W-1:0] num_sum;
  always_comb begin
    num_sum = '0;
    for (int j = 0; j <= KEYS; j++) begin
      num_sum = num_sum + wsk_pkg::NUM_W'(prod3_r[j]);
    end
  end

  // stage 4
  logic                             v4_r;
  logic signed [wsk_pkg::NUM_W-1:0] num4_r;
  logic [wsk_pkg::DEN_W-1:0]        den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num4_r <= num_sum;
      den4_r <= den3_r;
    end
  end

  assign valid_o = v4_r;
  assign num_o   = num4_r;
  assign den_o   = den4_r;

endmodule

### design/wsk_div_stage.sv
// one registered stage of the restoring divider, three quotient bits per stage
module wsk_div_stage #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  wsk_pkg::div_t d_i,
  output wsk_pkg::div_t d_o
);

  localparam int TOP_BIT = wsk_pkg::QUO_W - 1 - STAGE * wsk_pkg::BITS_PER_STAGE;

  wsk_pkg::div_t d_nxt;
  wsk_pkg::div_t d_r;
  logic [wsk_pkg::MAG_W-1:0] trial;

  always_comb begin
    d_nxt = d_i;
    trial = '0;
    for (int n = 0; n < wsk_pkg::BITS_PER_STAGE; n++) begin
      trial = wsk_pkg::MAG_W'(d_i.den) << (TOP_BIT - n);
      if (d_nxt.rem >= trial) begin
        d_nxt.rem             = d_nxt.rem - trial;
        d_nxt.quo[TOP_BIT-n]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

### design/weighted_scale_key_to_note_unit.sv
// top level of the weighted key-to-note unit
// Takes one key frame per clock while not stalled and returns one signed Q8.8
// note per frame, in order. Each accepted input transaction passes through four
// front stages (offset lookup, open-key weight, products, sums), five divider
// stages of three quotient bits each, and the output register. The pipeline
// moves as one; it stalls only while a result sits in the output register
// and the sink stalls, so with no sink stall it sustains one transaction per cycle.
// Configuration writes are always ready; write them only while the pipeline
// is empty. Tonic writes are reduced modulo 12, octave writes clamped to 1..8.
module weighted_scale_key_to_note_unit #(
  parameter int KEYS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_key_depths,
  input  logic               in_high_register,
  input  logic               in_low_register,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_note_q8,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  // configuration registers
  logic [3:0] tonic_r;
  logic [2:0] scale_r;
  logic [3:0] octave_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tonic_r  <= 4'd0;
      scale_r  <= 3'd0;
      octave_r <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsk_pkg::CFG_TONIC:  tonic_r  <= (cfg_data >= 4'd12) ? cfg_data - 4'd12 : cfg_data;
        wsk_pkg::CFG_SCALE:  scale_r  <= cfg_data[2:0];
        wsk_pkg::CFG_OCTAVE: octave_r <= (cfg_data == 4'd0) ? 4'd1 :
                                         (cfg_data > 4'd8) ? 4'd8 : cfg_data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // whole pipeline advances unless the result register is held
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic                             f_valid;
  logic signed [wsk_pkg::NUM_W-1:0] f_num;
  logic [wsk_pkg::DEN_W-1:0]        f_den;

  wsk_front #(.KEYS(KEYS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .key_depths    (in_key_depths),
    .high_register (in_high_register),
    .low_register  (in_low_register),
    .scale_type    (scale_r),
    .valid_o       (f_valid),
    .num_o         (f_num),
    .den_o         (f_den)
  );

  // divider input: magnitude of num * 256, sign kept aside for truncation toward zero
  wsk_pkg::div_t d [wsk_pkg::DIV_STAGES+1];
  logic [wsk_pkg::NUM_W-1:0] num_mag;
  assign num_mag = f_num[wsk_pkg::NUM_W-1] ? wsk_pkg::NUM_W'(-f_num) : wsk_pkg::NUM_W'(f_num);

  always_comb begin
    d[0].valid = f_valid;
    d[0].neg   = f_num[wsk_pkg::NUM_W-1];
    d[0].rem   = {wsk_pkg::MAG_W'(num_mag)} << 8;
    d[0].den   = f_den;
    d[0].quo   = '0;
  end

  for (genvar s = 0; s < wsk_pkg::DIV_STAGES; s++) begin : g_div
    wsk_div_stage #(.STAGE(s)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (d[s]),
      .d_o   (d[s+1])
    );
  end

  // signed mean plus 12 + 12 * octave + tonic, saturated to 16 bits
  wsk_pkg::div_t       dq;
  logic [6:0]          semis;
  logic signed [15:0]  mean;
  logic signed [17:0]  total;
  logic signed [15:0]  note_nxt;

  assign dq = d[wsk_pkg::DIV_STAGES];

  always_comb begin
    semis = 7'(12 + 12 * int'(octave_r) + int'(tonic_r));
    mean  = dq.neg ? -$signed({1'b0, dq.quo}) : $signed({1'b0, dq.quo});
    total = 18'(mean) + $signed({3'b0, semis, 8'b0});
    if (total > 18'sd32767) begin
      note_nxt = 16'sd32767;
    end else if (total < -18'sd32768) begin
      note_nxt = -16'sd32768;
    end else begin
      note_nxt = 16'(total);
    end
  end

  logic signed [15:0] out_note_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_note_r <= note_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_note_q8 = out_note_r;

  // checks
  logic [wsk_pkg::DIV_STAGES-1:0] div_v;
  for (genvar s = 0; s < wsk_pkg::DIV_STAGES; s++) begin : g_v
    assign div_v[s] = d[s+1].valid;
  end

  a_tonic_range: assert property (@(posedge clk) disable iff (!rst_n)
    tonic_r < 4'd12) else $error("tonic out of range");

  a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
    octave_r >= 4'd1 && octave_r <= 4'd8) else $error("octave out of range");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_v) && $stable(f_valid)) else $error("pipeline moved while stalled");

endmodule

### tb/weighted_scale_key_to_note_checker.sv
// checker: watches the key-to-note channels, predicts notes and compares them
`timescale 1ns / 1ps
module weighted_scale_key_to_note_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [63:0]        in_key_depths,
  input  logic               in_high_register,
  input  logic               in_low_register,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_note_q8,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int KEYS = 8;
  localparam int IVS [8][7] = '{
    '{2, 2, 1, 2, 2, 2, 1}, '{2, 1, 2, 2, 1, 2, 2}, '{2, 2, 3, 2, 3, 0, 0},
    '{3, 2, 1, 1, 3, 2, 0}, '{2, 0, 0, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0, 0},
    '{1, 2, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0}};
  localparam int REPS [8] = '{7, 7, 5, 6, 1, 2, 2, 1};
  localparam int OCTS [8] = '{7, 7, 5, 6, 6, 8, 8, 12};

  logic [3:0] tonic_r;
  logic [2:0] scale_r;
  logic [3:0] octave_r;
  logic signed [15:0] note_queue [$];

  function automatic logic signed [15:0] predict_note(logic [63:0] depths, logic hi, logic lo);
    int bk, boff, mag, key, off, maxd, down, d;
    int offs [KEYS+1];
    int w [KEYS+1];
    longint num, den, q;
    bk = 0; boff = 0; maxd = 0; down = 0; num = 0; den = 0;
    if (hi != lo) begin
      mag = 12;
      if (REPS[scale_r] <= 2) mag = (KEYS + 1) * (12 / (OCTS[scale_r] / REPS[scale_r]));
      if (hi) begin
        bk = KEYS + 1; boff = mag;
      end else begin
        bk = -(KEYS + 1); boff = -mag;
      end
      while (bk < 0) bk += OCTS[scale_r];
    end
    off = boff; key = bk;
    for (int i = 0; i <= KEYS; i++) begin
      offs[i] = off;
      off += IVS[scale_r][key % REPS[scale_r]];
      key++;
    end
    w[0] = 0;
    for (int i = 0; i < KEYS; i++) begin
      d = int'(depths[8*i +: 8]);
      w[i+1] = d;
      if (d > 0) down++;
      if (d > maxd) maxd = d;
    end
    if (down <= 1) w[0] = 255 - maxd;
    for (int i = 0; i <= KEYS; i++) begin
      num += longint'(w[i]) * offs[i];
      den += w[i];
    end
    q = (den != 0) ? (num * 256) / den : 0;
    q += longint'(12 + 12 * int'(octave_r) + int'(tonic_r)) * 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = note_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      tonic_r <= 4'd0; scale_r <= 3'd0; octave_r <= 4'd4;
      note_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        note_queue.push_back(predict_note(in_key_depths, in_high_register, in_low_register));
      if (out_valid && !out_stall) begin
        if (note_queue.size() == 0) report_mismatch("unexpected note", out_note_q8, 0);
        else begin
          if (out_note_q8 !== note_queue[0])
            report_mismatch("note_q8", out_note_q8, note_queue[0]);
          void'(note_queue.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wsk_pkg::CFG_TONIC:  tonic_r <= cfg_data % 4'd12;
          wsk_pkg::CFG_SCALE:  scale_r <= cfg_data[2:0];
          wsk_pkg::CFG_OCTAVE: octave_r <= (cfg_data < 4'd1) ? 4'd1 :
                                           (cfg_data > 4'd8) ? 4'd8 : cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

### tb/weighted_scale_key_to_note_unit_test.sv
// testbench top: stimulus, idling and verdict for the key-to-note unit
`timescale 1ns / 1ps
module weighted_scale_key_to_note_unit_test;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [63:0] in_key_depths;
  logic in_high_register, in_low_register;
  logic out_valid, out_stall;
  logic signed [15:0] out_note_q8;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;
  int fail_count, pending;
  int cycle_count;
  bit quiet_tail;     // no idling near the end
  int hold_off;       // long sink stall requested by stimulus

  localparam int LATENCY = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_NO_REG = 2'd3;  // index with no register behind it

  weighted_scale_key_to_note_unit u_top (.*);
  weighted_scale_key_to_note_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sink side: random stall bursts, plus the long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        n = hold_off;
        hold_off = 0;
        repeat (n) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // one input transaction, with an optional idle burst in front
  task automatic send_frame(logic [63:0] depths, logic hi, logic lo);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_depths <= depths;
    in_high_register <= hi;
    in_low_register <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain the pipeline before touching configuration
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // frame with a random number of keys down, mostly one or two
  function automatic logic [63:0] rand_depths();
    logic [63:0] v;
    int pick;
    v = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) v = {$urandom, $urandom};
    else if (pick == 1) v = '0;
    else begin
      for (int i = 0; i < $urandom_range(1, 3); i++)
        v[8*$urandom_range(0, 7) +: 8] = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
    end
    return v;
  endfunction

  initial begin
    logic hi, lo;
    in_valid = 1'b0; in_key_depths = '0; in_high_register = 1'b0; in_low_register = 1'b0;
    cfg_valid = 1'b0; cfg_index = wsk_pkg::CFG_TONIC; cfg_data = 4'd0;
    quiet_tail = 0; hold_off = 0; cycle_count = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes, both buttons
    send_frame(64'h0, 1'b0, 1'b0);
    send_frame({8{8'hff}}, 1'b0, 1'b0);
    send_frame({8{8'hff}}, 1'b1, 1'b1);
    send_frame(64'hff, 1'b1, 1'b0);
    send_frame(64'hff << 56, 1'b0, 1'b1);
    send_frame(64'h0000_0000_0000_8001, 1'b0, 1'b0);
    send_frame(64'h0000_0000_0000_0001, 1'b1, 1'b0);
    send_frame(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b1);
    send_frame(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    wait_idle();

    // saturation: high register at top octave, tonic out of range, octave clamps
    write_reg(wsk_pkg::CFG_OCTAVE, 4'd15);
    write_reg(wsk_pkg::CFG_TONIC, 4'd15);
    write_reg(wsk_pkg::CFG_SCALE, 4'd7);
    write_reg(CFG_NO_REG, 4'd9);
    send_frame({8{8'hff}}, 1'b1, 1'b0);
    send_frame(64'hff << 56, 1'b1, 1'b0);
    send_frame(64'h0, 1'b0, 1'b1);
    wait_idle();
    write_reg(wsk_pkg::CFG_OCTAVE, 4'd0);
    write_reg(wsk_pkg::CFG_TONIC, 4'd11);
    send_frame(64'hff << 56, 1'b0, 1'b1);
    send_frame({8{8'hff}}, 1'b0, 1'b1);
    send_frame(64'h0, 1'b0, 1'b0);

    // pressure: long sink hold-off while frames keep coming
    hold_off = 60;
    for (int i = 0; i < 30; i++) send_frame(rand_depths(), 1'($urandom), 1'($urandom));
    wait_idle();

    // random phases over every scale and random settings
    for (int phase = 0; phase < 16; phase++) begin
      write_reg(wsk_pkg::CFG_SCALE, 4'(phase % 8));
      write_reg(wsk_pkg::CFG_TONIC, 4'($urandom));
      write_reg(wsk_pkg::CFG_OCTAVE, (phase == 3) ? 4'd8 : (phase == 4) ? 4'd1 : 4'($urandom));
      if (phase == 14) quiet_tail = 1;
      for (int i = 0; i < 50; i++) begin
        hi = 1'($urandom); lo = 1'($urandom);
        send_frame(rand_depths(), hi, lo);
      end
      wait_idle();
    end

    repeat (LATENCY * 3) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
